@@ rtl/tmcw_pkg.sv @@
// Shared types, constants and helpers for the text mode console writer.
// No dependencies; every rtl module refers to this package by scoped names.
package tmcw_pkg;

   localparam int ROWS   = 25;
   localparam int COLS   = 80;
   localparam int CELLS  = ROWS * COLS;
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLS);
   localparam int ADDR_W = $clog2(CELLS);
   localparam int LIN_W  = (ADDR_W > 11) ? ADDR_W : 11;

   localparam int Q_DEPTH = 2;
   localparam int Q_AW    = $clog2(Q_DEPTH);

   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_RETURN  = 8'd13;
   localparam logic [7:0] CH_SPACE   = 8'd32;
   localparam logic [7:0] ATTR_RESET = 8'd15;

   localparam logic [2:0] OP_PUT_DEFAULT = 3'd0;
   localparam logic [2:0] OP_PUT_COLOR   = 3'd1;
   localparam logic [2:0] OP_BACKSPACE   = 3'd2;
   localparam logic [2:0] OP_CLEAR       = 3'd3;
   localparam logic [2:0] OP_SET_POS     = 3'd4;
   localparam logic [2:0] OP_READ_CELL   = 3'd5;

   localparam logic [ROW_W-1:0]  LAST_ROW        = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  LAST_COL        = COL_W'(COLS - 1);
   localparam logic [ROW_W-1:0]  ROW_ONE         = ROW_W'(1);
   localparam logic [COL_W-1:0]  COL_ONE         = COL_W'(1);
   localparam logic [ADDR_W-1:0] ADDR_ONE        = ADDR_W'(1);
   localparam logic [ADDR_W-1:0] ADDR_LAST       = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] ADDR_ROW_STRIDE = ADDR_W'(COLS);
   localparam logic [ADDR_W-1:0] ADDR_LAST_ROW   = ADDR_W'(CELLS - COLS);

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] char_code;
      logic [7:0] color;
      logic [4:0] row;
      logic [6:0] col;
   } req_type;

   typedef struct packed {
      logic [4:0]  cursor_row_out;
      logic [6:0]  cursor_col_out;
      logic [10:0] cursor_offset;
      logic [7:0]  read_char;
      logic [7:0]  read_attr;
   } rsp_type;

   typedef enum logic [2:0] {
      CMD_PUT,
      CMD_NEWLINE,
      CMD_RETURN,
      CMD_BACKSPACE,
      CMD_CLEAR,
      CMD_SET_POS,
      CMD_READ,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [7:0]       ch;
      logic [7:0]       attr;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_IDLE,
      ST_READ,
      ST_COPY,
      ST_DRAIN
   } back_state_type;

   typedef struct packed {
      logic init;      // power-up clearing pass running
      logic pop;       // command taken from the queue this cycle
      logic pop_read;  // taken command is a cell read
   } back_status_type;

   function automatic logic [LIN_W-1:0] lin_index(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
      return LIN_W'(r) * LIN_W'(COLS) + LIN_W'(c);
   endfunction

endpackage

@@ rtl/tmcw_front.sv @@
// Front end: accepts requests, holds the default attribute register and
// turns each request into a decoded command. Depends on tmcw_pkg.
module tmcw_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  tmcw_pkg::req_type  req,
   input  logic               csr_wr_en,
   input  logic [7:0]         csr_wr_data,
   input  logic               q_full,
   input  logic               init_busy,
   output logic               busy,
   output logic               push,
   output tmcw_pkg::cmd_type  push_cmd,
   output logic [7:0]         default_attr
);

   logic [7:0] attr_ff;
   logic [7:0] attr_in;
   logic [tmcw_pkg::ROW_W-1:0] sat_row;
   logic [tmcw_pkg::COL_W-1:0] sat_col;

   always_comb begin
      attr_in = attr_ff;
      if (csr_wr_en) begin
         attr_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= tmcw_pkg::ATTR_RESET;
      end else begin
         attr_ff <= attr_in;
      end
   end

   assign default_attr = attr_ff;
   assign busy         = q_full || init_busy;
   assign push         = start && !busy;

   always_comb begin
      if (32'(req.row) >= 32'(tmcw_pkg::ROWS)) begin
         sat_row = tmcw_pkg::LAST_ROW;
      end else begin
         sat_row = tmcw_pkg::ROW_W'(req.row);
      end
      if (32'(req.col) >= 32'(tmcw_pkg::COLS)) begin
         sat_col = tmcw_pkg::LAST_COL;
      end else begin
         sat_col = tmcw_pkg::COL_W'(req.col);
      end
   end

   always_comb begin
      push_cmd.ch   = req.char_code;
      push_cmd.attr = attr_ff;
      push_cmd.row  = sat_row;
      push_cmd.col  = sat_col;
      case (req.operation)
         tmcw_pkg::OP_PUT_DEFAULT: begin
            if (req.char_code == tmcw_pkg::CH_NEWLINE) begin
               push_cmd.kind = tmcw_pkg::CMD_NEWLINE;
            end else if (req.char_code == tmcw_pkg::CH_RETURN) begin
               push_cmd.kind = tmcw_pkg::CMD_RETURN;
            end else begin
               push_cmd.kind = tmcw_pkg::CMD_PUT;
            end
         end
         tmcw_pkg::OP_PUT_COLOR: begin
            push_cmd.attr = req.color;
            if (req.char_code == tmcw_pkg::CH_NEWLINE) begin
               push_cmd.kind = tmcw_pkg::CMD_NEWLINE;
            end else begin
               push_cmd.kind = tmcw_pkg::CMD_PUT;
            end
         end
         tmcw_pkg::OP_BACKSPACE: push_cmd.kind = tmcw_pkg::CMD_BACKSPACE;
         tmcw_pkg::OP_CLEAR:     push_cmd.kind = tmcw_pkg::CMD_CLEAR;
         tmcw_pkg::OP_SET_POS:   push_cmd.kind = tmcw_pkg::CMD_SET_POS;
         tmcw_pkg::OP_READ_CELL: push_cmd.kind = tmcw_pkg::CMD_READ;
         default:                push_cmd.kind = tmcw_pkg::CMD_NOP;
      endcase
   end

endmodule

@@ rtl/tmcw_queue.sv @@
// Small command FIFO between front end and back end.
// Depends on tmcw_pkg for the command type and depth.
module tmcw_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tmcw_pkg::cmd_type  push_cmd,
   input  logic               pop,
   output tmcw_pkg::cmd_type  head,
   output logic               full,
   output logic               empty
);

   tmcw_pkg::cmd_type entry_ff [tmcw_pkg::Q_DEPTH];
   logic [tmcw_pkg::Q_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tmcw_pkg::Q_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tmcw_pkg::Q_AW:0]   count_ff, count_in;

   assign full  = (32'(count_ff) == tmcw_pkg::Q_DEPTH);
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == tmcw_pkg::Q_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == tmcw_pkg::Q_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/tmcw_back.sv @@
// Back end: owns the cell store and the cursor, executes commands, runs the
// clear, scroll and power-up sweeps and registers the results. Uses tmcw_pkg.
module tmcw_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_empty,
   input  tmcw_pkg::cmd_type        q_head,
   input  logic [7:0]               default_attr,
   output logic                     pop,
   output tmcw_pkg::back_status_type status,
   output logic                     rsp_valid,
   output tmcw_pkg::rsp_type        rsp_data
);

   tmcw_pkg::back_state_type state_ff, state_in;

   logic [tmcw_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [tmcw_pkg::COL_W-1:0]  col_ff, col_in;
   logic [tmcw_pkg::ADDR_W-1:0] cnt_ff, cnt_in;
   logic [7:0]                  fill_attr_ff, fill_attr_in;
   logic                        init_ff, init_in;
   logic                        wr_pend_ff, wr_pend_in;
   logic [tmcw_pkg::ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   tmcw_pkg::rsp_type           rsp_ff, rsp_in;

   logic [15:0] mem [tmcw_pkg::CELLS];
   logic [15:0] rd_data_ff;

   logic                        mem_we;
   logic [tmcw_pkg::ADDR_W-1:0] mem_waddr;
   logic [15:0]                 mem_wdata;
   logic [tmcw_pkg::ADDR_W-1:0] mem_raddr;

   // decoded effect of the head command
   logic [tmcw_pkg::ROW_W-1:0]  dec_row;
   logic [tmcw_pkg::COL_W-1:0]  dec_col;
   logic [tmcw_pkg::ROW_W-1:0]  dec_arow;
   logic [tmcw_pkg::COL_W-1:0]  dec_acol;
   logic                        dec_we;
   logic [15:0]                 dec_wdata;
   logic                        dec_scroll;
   logic                        dec_fill;
   logic                        dec_read;
   logic [tmcw_pkg::LIN_W-1:0]  dec_lin;
   logic [tmcw_pkg::ADDR_W-1:0] dec_addr;

   function automatic tmcw_pkg::rsp_type make_rsp(input logic [tmcw_pkg::ROW_W-1:0] r,
                                                  input logic [tmcw_pkg::COL_W-1:0] c,
                                                  input logic [15:0] cell_data);
      tmcw_pkg::rsp_type rsp;
      logic [tmcw_pkg::LIN_W-1:0] lin;
      lin                = tmcw_pkg::lin_index(r, c);
      rsp.cursor_row_out = 5'(r);
      rsp.cursor_col_out = 7'(c);
      rsp.cursor_offset  = lin[10:0];
      rsp.read_char      = cell_data[7:0];
      rsp.read_attr      = cell_data[15:8];
      return rsp;
   endfunction

   assign pop = (state_ff == tmcw_pkg::ST_IDLE) && !q_empty;

   always_comb begin
      dec_row    = row_ff;
      dec_col    = col_ff;
      dec_arow   = row_ff;
      dec_acol   = col_ff;
      dec_we     = 1'b0;
      dec_wdata  = {default_attr, tmcw_pkg::CH_SPACE};
      dec_scroll = 1'b0;
      dec_fill   = 1'b0;
      dec_read   = 1'b0;
      case (q_head.kind)
         tmcw_pkg::CMD_PUT: begin
            dec_we    = 1'b1;
            dec_wdata = {q_head.attr, q_head.ch};
            if (col_ff == tmcw_pkg::LAST_COL) begin
               dec_col = '0;
               if (row_ff == tmcw_pkg::LAST_ROW) begin
                  dec_scroll = 1'b1;
               end else begin
                  dec_row = row_ff + tmcw_pkg::ROW_ONE;
               end
            end else begin
               dec_col = col_ff + tmcw_pkg::COL_ONE;
            end
         end
         tmcw_pkg::CMD_NEWLINE: begin
            dec_col = '0;
            if (row_ff == tmcw_pkg::LAST_ROW) begin
               dec_scroll = 1'b1;
            end else begin
               dec_row = row_ff + tmcw_pkg::ROW_ONE;
            end
         end
         tmcw_pkg::CMD_RETURN: dec_col = '0;
         tmcw_pkg::CMD_BACKSPACE: begin
            if (col_ff != '0) begin
               dec_col = col_ff - tmcw_pkg::COL_ONE;
               dec_we  = 1'b1;
            end else if (row_ff != '0) begin
               dec_row = row_ff - tmcw_pkg::ROW_ONE;
               dec_col = tmcw_pkg::LAST_COL;
               dec_we  = 1'b1;
            end
            dec_arow = dec_row;
            dec_acol = dec_col;
         end
         tmcw_pkg::CMD_CLEAR: begin
            dec_row  = '0;
            dec_col  = '0;
            dec_fill = 1'b1;
         end
         tmcw_pkg::CMD_SET_POS: begin
            dec_row = q_head.row;
            dec_col = q_head.col;
         end
         tmcw_pkg::CMD_READ: begin
            dec_arow = q_head.row;
            dec_acol = q_head.col;
            dec_read = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign dec_lin  = tmcw_pkg::lin_index(dec_arow, dec_acol);
   assign dec_addr = dec_lin[tmcw_pkg::ADDR_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tmcw_pkg::ST_FILL: begin
            if (cnt_ff == tmcw_pkg::ADDR_LAST) begin
               state_in = tmcw_pkg::ST_IDLE;
            end
         end
         tmcw_pkg::ST_IDLE: begin
            if (pop) begin
               if (dec_read) begin
                  state_in = tmcw_pkg::ST_READ;
               end else if (dec_fill) begin
                  state_in = tmcw_pkg::ST_FILL;
               end else if (dec_scroll) begin
                  state_in = tmcw_pkg::ST_COPY;
               end
            end
         end
         tmcw_pkg::ST_READ: state_in = tmcw_pkg::ST_IDLE;
         tmcw_pkg::ST_COPY: begin
            if (cnt_ff == tmcw_pkg::ADDR_LAST) begin
               state_in = tmcw_pkg::ST_DRAIN;
            end
         end
         tmcw_pkg::ST_DRAIN: state_in = tmcw_pkg::ST_FILL;
         default: state_in = tmcw_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      cnt_in       = cnt_ff;
      fill_attr_in = fill_attr_ff;
      init_in      = init_ff;
      wr_pend_in   = 1'b0;
      wr_addr_in   = wr_addr_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = cnt_ff;
      mem_wdata    = {fill_attr_ff, tmcw_pkg::CH_SPACE};
      mem_raddr    = cnt_ff;
      case (state_ff)
         tmcw_pkg::ST_FILL: begin
            mem_we = 1'b1;
            cnt_in = cnt_ff + tmcw_pkg::ADDR_ONE;
            if (cnt_ff == tmcw_pkg::ADDR_LAST) begin
               init_in = 1'b0;
            end
         end
         tmcw_pkg::ST_IDLE: begin
            mem_raddr = dec_addr;
            if (pop) begin
               mem_we    = dec_we;
               mem_waddr = dec_addr;
               mem_wdata = dec_wdata;
               row_in    = dec_row;
               col_in    = dec_col;
               if (dec_fill) begin
                  cnt_in       = '0;
                  fill_attr_in = default_attr;
               end
               if (dec_scroll) begin
                  cnt_in       = tmcw_pkg::ADDR_ROW_STRIDE;
                  fill_attr_in = default_attr;
               end
               // cursor result does not depend on the sweep, so report now
               if (!dec_read) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = make_rsp(dec_row, dec_col, 16'h0000);
               end
            end
         end
         tmcw_pkg::ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_in       = make_rsp(row_ff, col_ff, rd_data_ff);
         end
         tmcw_pkg::ST_COPY: begin
            // read a cell one row below its target, write it there in the next cycle
            mem_raddr  = cnt_ff;
            wr_pend_in = 1'b1;
            wr_addr_in = cnt_ff - tmcw_pkg::ADDR_ROW_STRIDE;
            mem_we     = wr_pend_ff;
            mem_waddr  = wr_addr_ff;
            mem_wdata  = rd_data_ff;
            cnt_in     = cnt_ff + tmcw_pkg::ADDR_ONE;
         end
         tmcw_pkg::ST_DRAIN: begin
            mem_we    = wr_pend_ff;
            mem_waddr = wr_addr_ff;
            mem_wdata = rd_data_ff;
            cnt_in    = tmcw_pkg::ADDR_LAST_ROW;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tmcw_pkg::ST_FILL;
         row_ff       <= '0;
         col_ff       <= '0;
         cnt_ff       <= '0;
         fill_attr_ff <= tmcw_pkg::ATTR_RESET;
         init_ff      <= 1'b1;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         cnt_ff       <= cnt_in;
         fill_attr_ff <= fill_attr_in;
         init_ff      <= init_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= wr_addr_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   assign status.init     = init_ff;
   assign status.pop      = pop;
   assign status.pop_read = pop && dec_read;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/text_mode_console_writer.sv @@
// Top level of the text mode console writer: front end, command queue and
// back end with the cell store. Depends on tmcw_pkg and the tmcw_* modules.
//
//   channel   ports                          handshake
//   request   start, busy, req_data          taken when start && !busy
//   result    rsp_valid, rsp_data            one-cycle strobe, no back-pressure
//   csr       csr_wr_en, csr_wr_data         default attribute, written at once
//
// Characters, returns, backspace, set position: one item per cycle unless a scroll
// or clear holds the back end; the result is registered in the back end. Cell reads
// pass the registered memory read port, then the ST_READ state. A scroll holds the
// back end for the row copy plus last-row blank, a clear for a sweep of all
// CELLS = ROWS*COLS = 2000 cells. After reset, busy stays high for the clearing pass
// of the store. busy also rises when the two-entry command queue is full.
module text_mode_console_writer (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  tmcw_pkg::req_type  req_data,
   output logic               rsp_valid,
   output tmcw_pkg::rsp_type  rsp_data,
   input  logic               csr_wr_en,
   input  logic [7:0]         csr_wr_data
);

   logic                      push;
   tmcw_pkg::cmd_type         push_cmd;
   tmcw_pkg::cmd_type         q_head;
   logic                      q_full;
   logic                      q_empty;
   logic                      pop;
   logic [7:0]                default_attr;
   tmcw_pkg::back_status_type status;

   tmcw_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req          (req_data),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .q_full       (q_full),
      .init_busy    (status.init),
      .busy         (busy),
      .push         (push),
      .push_cmd     (push_cmd),
      .default_attr (default_attr)
   );

   tmcw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (q_head),
      .full     (q_full),
      .empty    (q_empty)
   );

   tmcw_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_head       (q_head),
      .default_attr (default_attr),
      .pop          (pop),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_no_rsp_during_init: assert property (@(posedge clock) disable iff (reset)
      status.init |-> !rsp_valid)
      else $error("result strobe during power-up clearing pass");

   a_rsp_after_pop: assert property (@(posedge clock) disable iff (reset)
      (status.pop && !status.pop_read) |=> rsp_valid)
      else $error("missing result one cycle after command dispatch");

   a_rsp_after_read: assert property (@(posedge clock) disable iff (reset)
      status.pop_read |=> ##1 rsp_valid)
      else $error("missing result two cycles after cell read dispatch");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !push)
      else $error("transaction pushed into a full command queue");
`endif

endmodule

@@ sim/text_mode_console_writer_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for text_mode_console_writer: a shadow console predicts
// every cursor report and cell read. Depends on tmcw_pkg and the rtl modules only.
module text_mode_console_writer_tb;

   localparam logic [2:0] OP_UNUSED_A = 3'd6;
   localparam logic [2:0] OP_UNUSED_B = 3'd7;

   // Shadow copy of the screen, cursor and default attribute.
   // Each transaction pushes one expected cursor report.
   class console_shadow;
      logic [15:0]       glyphs [tmcw_pkg::CELLS];
      int unsigned       cur_r, cur_c;
      logic [7:0]        default_attr;
      tmcw_pkg::rsp_type pending [$];
      int unsigned       mismatches, commands, reads, walks;

      function new();
         default_attr = tmcw_pkg::ATTR_RESET;
         cur_r = 0;
         cur_c = 0;
         blank_all();
      endfunction

      function void blank_all();
         for (int i = 0; i < tmcw_pkg::CELLS; i++)
            glyphs[i] = {default_attr, tmcw_pkg::CH_SPACE};
      endfunction

      function int unsigned clamp(int unsigned v, int unsigned lim);
         return (v >= lim) ? lim - 1 : v;
      endfunction

      function void put_glyph(logic [7:0] ch, logic [7:0] attr);
         glyphs[cur_r * tmcw_pkg::COLS + cur_c] = {attr, ch};
         cur_c++;
      endfunction

      // column wrap, then scroll at the bottom edge
      function void settle();
         if (cur_c >= tmcw_pkg::COLS) begin
            cur_c = 0;
            cur_r++;
         end
         if (cur_r >= tmcw_pkg::ROWS) begin
            for (int i = 0; i < tmcw_pkg::CELLS - tmcw_pkg::COLS; i++)
               glyphs[i] = glyphs[i + tmcw_pkg::COLS];
            for (int i = tmcw_pkg::CELLS - tmcw_pkg::COLS; i < tmcw_pkg::CELLS; i++)
               glyphs[i] = {default_attr, tmcw_pkg::CH_SPACE};
            cur_r = tmcw_pkg::ROWS - 1;
            walks++;
         end
      endfunction

      function void take_command(tmcw_pkg::req_type r);
         int unsigned idx;
         tmcw_pkg::rsp_type want;
         want = '0;
         commands++;
         case (r.operation)
            tmcw_pkg::OP_PUT_DEFAULT: begin
               if (r.char_code == tmcw_pkg::CH_NEWLINE) begin
                  cur_c = 0;
                  cur_r++;
               end else if (r.char_code == tmcw_pkg::CH_RETURN) begin
                  cur_c = 0;
               end else begin
                  put_glyph(r.char_code, default_attr);
               end
               settle();
            end
            tmcw_pkg::OP_PUT_COLOR: begin
               if (r.char_code == tmcw_pkg::CH_NEWLINE) begin
                  cur_c = 0;
                  cur_r++;
               end else begin
                  put_glyph(r.char_code, r.color);
               end
               settle();
            end
            tmcw_pkg::OP_BACKSPACE: begin
               // stuck at top-left; otherwise step back, across a line start if needed
               if (cur_c > 0 || cur_r > 0) begin
                  if (cur_c > 0) begin
                     cur_c--;
                  end else begin
                     cur_r--;
                     cur_c = tmcw_pkg::COLS - 1;
                  end
                  glyphs[cur_r * tmcw_pkg::COLS + cur_c] = {default_attr, tmcw_pkg::CH_SPACE};
               end
            end
            tmcw_pkg::OP_CLEAR: begin
               blank_all();
               cur_r = 0;
               cur_c = 0;
               walks++;
            end
            tmcw_pkg::OP_SET_POS: begin
               cur_r = clamp(r.row, tmcw_pkg::ROWS);
               cur_c = clamp(r.col, tmcw_pkg::COLS);
            end
            tmcw_pkg::OP_READ_CELL: begin
               idx = clamp(r.row, tmcw_pkg::ROWS) * tmcw_pkg::COLS
                     + clamp(r.col, tmcw_pkg::COLS);
               want.read_char = glyphs[idx][7:0];
               want.read_attr = glyphs[idx][15:8];
               reads++;
            end
            default: ;
         endcase
         want.cursor_row_out = 5'(cur_r);
         want.cursor_col_out = 7'(cur_c);
         want.cursor_offset  = 11'(cur_r * tmcw_pkg::COLS + cur_c);
         pending.push_back(want);
      endfunction

      function void compare(string field, logic [10:0] want_v, logic [10:0] got_v);
         if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
            mismatches++;
         end
      endfunction

      function void check_report(tmcw_pkg::rsp_type got);
         tmcw_pkg::rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %p", $time, got);
            mismatches++;
            return;
         end
         want = pending.pop_front();
         compare("cursor_row_out", 11'(want.cursor_row_out), 11'(got.cursor_row_out));
         compare("cursor_col_out", 11'(want.cursor_col_out), 11'(got.cursor_col_out));
         compare("cursor_offset", want.cursor_offset, got.cursor_offset);
         compare("read_char", 11'(want.read_char), 11'(got.read_char));
         compare("read_attr", 11'(want.read_attr), 11'(got.read_attr));
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   tmcw_pkg::req_type req_data = '0;
   logic              rsp_valid;
   tmcw_pkg::rsp_type rsp_data;
   logic              csr_wr_en = 1'b0;
   logic [7:0]        csr_wr_data = '0;

   console_shadow sb;
   int unsigned   burst_left = 0;
   int unsigned   sent = 0;

   text_mode_console_writer u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.check_report(rsp_data);
         if (start && !busy) sb.take_command(req_data);
         if (csr_wr_en) sb.default_attr = csr_wr_data;
      end
   end

   // One transaction; the sender may idle between bursts of random length.
   task automatic send(input logic [2:0] op, input logic [7:0] ch, input logic [7:0] attr,
                       input logic [4:0] r, input logic [6:0] c);
      int unsigned gap;
      if (burst_left == 0) begin
         case ($urandom_range(0, 9))
            0:       gap = 0;
            1, 2, 3: gap = $urandom_range(1, 3);
            4, 5, 6: gap = $urandom_range(4, 12);
            7, 8:    gap = 1;
            default: gap = $urandom_range(20, 60);
         endcase
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 12);
         if (gap != 0) begin
            start    <= 1'b0;
            req_data <= 31'($urandom);
            repeat (gap) @(posedge clock);
         end
      end
      start    <= 1'b1;
      req_data <= '{operation: op, char_code: ch, color: attr, row: r, col: c};
      @(posedge clock);
      while (busy) @(posedge clock);
      burst_left--;
      sent++;
   endtask

   task automatic drain(input int unsigned tail);
      start      <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   // The back end may still be walking the store after the last report.
   task automatic change_attr(input logic [7:0] value);
      drain(2100);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic mix(input int unsigned n);
      int unsigned stop_at, pick, len, r, c;
      logic [7:0]  ch;
      stop_at = sent + n;
      while (sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            // text run from a fresh position, then read some of it back
            r = ($urandom_range(0, 7) == 0) ? 24 : $urandom_range(0, 23);
            c = $urandom_range(0, 79);
            send(tmcw_pkg::OP_SET_POS, 8'($urandom), 8'($urandom), 5'(r), 7'(c));
            len = $urandom_range(1, 30);
            repeat (len) begin
               ch = 8'($urandom);
               pick = $urandom_range(0, 11);
               if (pick == 0) ch = tmcw_pkg::CH_NEWLINE;
               else if (pick == 1) ch = tmcw_pkg::CH_RETURN;
               send($urandom_range(0, 1) ? tmcw_pkg::OP_PUT_COLOR : tmcw_pkg::OP_PUT_DEFAULT,
                    ch, 8'($urandom), 5'($urandom), 7'($urandom));
            end
            repeat ($urandom_range(1, 4))
               send(tmcw_pkg::OP_READ_CELL, 8'($urandom), 8'($urandom), 5'(r),
                    7'(c + $urandom_range(0, len)));
         end else if (pick < 55) begin
            r = $urandom_range(0, 24);
            c = $urandom_range(0, 1) ? 0 : $urandom_range(0, 79);
            if ($urandom_range(0, 5) == 0) begin
               r = 0;
               c = $urandom_range(0, 3);
            end
            send(tmcw_pkg::OP_SET_POS, 8'($urandom), 8'($urandom), 5'(r), 7'(c));
            repeat ($urandom_range(1, 12))
               send(tmcw_pkg::OP_BACKSPACE, 8'($urandom), 8'($urandom), 5'($urandom),
                    7'($urandom));
            send(tmcw_pkg::OP_READ_CELL, 8'($urandom), 8'($urandom), 5'(r),
                 7'($urandom_range(0, 79)));
            send(tmcw_pkg::OP_READ_CELL, 8'($urandom), 8'($urandom),
                 5'((r == 0) ? 0 : r - 1), 7'(79));
         end else if (pick < 70) begin
            repeat ($urandom_range(1, 6))
               send(tmcw_pkg::OP_READ_CELL, 8'($urandom), 8'($urandom), 5'($urandom),
                    7'($urandom));
         end else if (pick < 80) begin
            // push text off the bottom row
            send(tmcw_pkg::OP_SET_POS, 8'($urandom), 8'($urandom), 5'(24),
                 7'($urandom_range(70, 79)));
            repeat ($urandom_range(1, 15)) begin
               ch = ($urandom_range(0, 5) == 0) ? tmcw_pkg::CH_NEWLINE : 8'($urandom);
               send($urandom_range(0, 1) ? tmcw_pkg::OP_PUT_COLOR : tmcw_pkg::OP_PUT_DEFAULT,
                    ch, 8'($urandom), 5'($urandom), 7'($urandom));
            end
            repeat ($urandom_range(1, 3))
               send(tmcw_pkg::OP_READ_CELL, 8'($urandom), 8'($urandom),
                    5'($urandom_range(22, 24)), 7'($urandom_range(0, 79)));
         end else if (pick < 83) begin
            send(tmcw_pkg::OP_CLEAR, 8'($urandom), 8'($urandom), 5'($urandom), 7'($urandom));
            send(tmcw_pkg::OP_READ_CELL, 8'($urandom), 8'($urandom), 5'($urandom),
                 7'($urandom));
         end else begin
            repeat ($urandom_range(1, 5))
               send(3'($urandom), 8'($urandom), 8'($urandom), 5'($urandom), 7'($urandom));
         end
      end
   endtask

   initial begin
      int unsigned errors;
      logic [7:0]  last_attr;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, every operation, the corner cases of the cursor
      send(tmcw_pkg::OP_READ_CELL, 8'h00, 8'h00, 5'd0, 7'd0);
      send(tmcw_pkg::OP_PUT_DEFAULT, 8'h41, 8'h00, 5'd0, 7'd0);
      send(tmcw_pkg::OP_PUT_COLOR, 8'hFF, 8'hFF, 5'd0, 7'd0);
      send(tmcw_pkg::OP_PUT_DEFAULT, 8'h00, 8'h00, 5'd31, 7'd127);
      send(tmcw_pkg::OP_PUT_DEFAULT, tmcw_pkg::CH_RETURN, 8'h55, 5'd0, 7'd0);
      send(tmcw_pkg::OP_PUT_COLOR, tmcw_pkg::CH_RETURN, 8'h00, 5'd0, 7'd0);
      send(tmcw_pkg::OP_PUT_DEFAULT, tmcw_pkg::CH_NEWLINE, 8'h00, 5'd0, 7'd0);
      send(tmcw_pkg::OP_PUT_COLOR, tmcw_pkg::CH_NEWLINE, 8'hAA, 5'd0, 7'd0);
      send(tmcw_pkg::OP_BACKSPACE, 8'h00, 8'h00, 5'd0, 7'd0);
      send(tmcw_pkg::OP_READ_CELL, 8'h00, 8'h00, 5'd0, 7'd1);
      send(tmcw_pkg::OP_SET_POS, 8'h00, 8'h00, 5'd0, 7'd0);
      send(tmcw_pkg::OP_BACKSPACE, 8'hFF, 8'hFF, 5'd31, 7'd127);
      send(tmcw_pkg::OP_SET_POS, 8'h00, 8'h00, 5'd31, 7'd127);
      send(tmcw_pkg::OP_PUT_DEFAULT, 8'h5A, 8'h00, 5'd0, 7'd0);
      send(tmcw_pkg::OP_READ_CELL, 8'h00, 8'h00, 5'd23, 7'd79);
      send(tmcw_pkg::OP_READ_CELL, 8'h00, 8'h00, 5'd31, 7'd127);
      send(tmcw_pkg::OP_SET_POS, 8'h00, 8'h00, 5'd24, 7'd5);
      send(tmcw_pkg::OP_PUT_COLOR, tmcw_pkg::CH_NEWLINE, 8'h00, 5'd0, 7'd0);
      send(OP_UNUSED_A, 8'hFF, 8'hFF, 5'd31, 7'd127);
      send(OP_UNUSED_B, 8'h0F, 8'hF0, 5'd1, 7'd1);
      send(tmcw_pkg::OP_BACKSPACE, 8'h00, 8'h00, 5'd0, 7'd0);
      send(tmcw_pkg::OP_READ_CELL, 8'h00, 8'h00, 5'd22, 7'd79);
      send(tmcw_pkg::OP_CLEAR, 8'h00, 8'h00, 5'd0, 7'd0);
      send(tmcw_pkg::OP_READ_CELL, 8'h00, 8'h00, 5'd22, 7'd79);

      mix(240);
      change_attr(8'h00);
      mix(260);
      change_attr(8'hFF);
      mix(260);
      last_attr = 8'($urandom);
      change_attr(last_attr);
      mix(260);
      drain(100);

      errors = sb.mismatches + sb.pending.size();
      $display("Ran %0d console commands: %0d cell reads, %0d scrolls or clears.",
               sb.commands, sb.reads, sb.walks);
      $display("Default attribute settings used: 0x0f, 0x00, 0xff, 0x%02h.", last_attr);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #84_000_000;
      $display("Timeout with %0d results outstanding", sb.pending.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ text_mode_console_writer.f @@
rtl/tmcw_pkg.sv
rtl/tmcw_front.sv
rtl/tmcw_queue.sv
rtl/tmcw_back.sv
rtl/text_mode_console_writer.sv
sim/text_mode_console_writer_tb.sv
